### hw/rtl/assert_macros.svh
// assertion macros for the rtl modules; the sorted record table unit includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SRT_ASSERT_NOW(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication, checked outside reset
`define SRT_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

### hw/rtl/srt_pkg.sv
// shared types and constants of the sorted record table
package srt_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int NAME_CHARS_DEF = 25;
    localparam int MAX_OUT        = 64;
    localparam int NAME_PORT_W    = 200;

    typedef enum logic [1:0] {
        F_INSERT = 2'd0,
        F_SEARCH = 2'd1,
        F_UPDATE = 2'd2,
        F_LIST   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_LIST
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic upd;
        logic rot;
    } t_cell_cmd;

    // per-cell status seen by the neighbor and the top level
    typedef struct packed {
        logic valid;
        logic gt;
        logic eq;
    } t_cell_flag;

endpackage

### hw/rtl/srt_if.sv
// handshake channels for request and result words
interface srt_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [31:0] part_key;
    logic signed [31:0] amount;
    logic [63:0]       name_word0;
    logic [63:0]       name_word1;
    logic [63:0]       name_word2;
    logic [7:0]        name_tail;

    modport source (
        output valid, func, part_key, amount, name_word0, name_word1, name_word2,
               name_tail,
        input  ready
    );
    modport sink (
        input  valid, func, part_key, amount, name_word0, name_word1, name_word2,
               name_tail,
        output ready
    );
endinterface

interface srt_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic signed [31:0] found_key;
    logic signed [31:0] found_amount;
    logic [63:0]       out_word0;
    logic [63:0]       out_word1;
    logic [63:0]       out_word2;
    logic [7:0]        out_tail;
    logic              last;

    modport source (
        output valid, status, found_key, found_amount, out_word0, out_word1,
               out_word2, out_tail, last,
        input  ready
    );
    modport sink (
        input  valid, status, found_key, found_amount, out_word0, out_word1,
               out_word2, out_tail, last,
        output ready
    );
endinterface

### hw/rtl/sorted_record_table_unit.sv
// sorted record table: chain of record cells with a control sequencer
//
//  channel  | dir | word
//  ---------+-----+-----------------------------------------------------
//  i_in     | in  | func, part_key, amount, name_word0..2, name_tail
//  o_out    | out | status, found_key, found_amount, out_word0..2, out_tail, last
//
// insert, search and update: accept, a key compare in every cell at once, then the
// apply step that loads the result into the output register; a new request is taken
// only after the apply step has loaded its result, so one request is in progress at a time
// list: accept and compare, then one record loaded per cycle, unless stalled, as the chain
// rotates through its entry_count filled cells; an empty table gives no word
// reset clears the count and valid flags; a stalled result holds apply and rotation
module sorted_record_table_unit import srt_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_CHARS = NAME_CHARS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srt_in_if.sink    i_in,
    srt_out_if.source o_out
);

`include "assert_macros.svh"

    localparam int NAME_W = NAME_CHARS * 8;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // sequencer and request registers
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   n_idx;
    t_func              r_func;
    logic signed [31:0] r_key;
    logic signed [31:0] r_amount;
    logic [NAME_W-1:0]  r_name;

    // output register
    logic                   r_ov;
    t_status                r_ost;
    logic signed [31:0]     r_okey;
    logic signed [31:0]     r_oamt;
    logic [NAME_PORT_W-1:0] r_oname;
    logic                   r_olast;

    // result being loaded this cycle
    logic                   load_out;
    t_status                res_st;
    logic signed [31:0]     res_key;
    logic signed [31:0]     res_amt;
    logic [NAME_PORT_W-1:0] res_name;
    logic                   res_last;

    t_cell_cmd cmd;
    logic      in_acc;
    logic      out_free;
    logic      hit;
    logic      full;
    logic      emit;
    int        list_n;

    // cell chain wiring
    t_cell_flag         c_flag  [CAPACITY];
    logic signed [31:0] c_key   [CAPACITY];
    logic signed [31:0] c_amt   [CAPACITY];
    logic [NAME_W-1:0]  c_name  [CAPACITY];
    logic signed [31:0] s_key   [CAPACITY];
    logic signed [31:0] s_amt   [CAPACITY];
    logic [NAME_W-1:0]  s_name  [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] valid_vec;
    logic signed [31:0] sel_key;
    logic signed [31:0] sel_amt;
    logic [NAME_W-1:0]  sel_name;

    logic [NAME_PORT_W-1:0] in_name_full;

    assign in_name_full = {i_in.name_tail, i_in.name_word2, i_in.name_word1,
                           i_in.name_word0};
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign full     = (r_count == CNT_W'(CAPACITY));

    // the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_flag         left_flag;
        logic signed [31:0] left_key;
        logic signed [31:0] left_amt;
        logic [NAME_W-1:0]  left_name;
        logic               right_valid;
        logic signed [31:0] right_key;
        logic signed [31:0] right_amt;
        logic [NAME_W-1:0]  right_name;

        if (g == 0) begin : g_first
            assign left_flag = '{valid: 1'b0, gt: 1'b1, eq: 1'b0};
            assign left_key  = '0;
            assign left_amt  = '0;
            assign left_name = '0;
        end else begin : g_mid
            assign left_flag = c_flag[g-1];
            assign left_key  = c_key[g-1];
            assign left_amt  = c_amt[g-1];
            assign left_name = c_name[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign right_valid = 1'b0;
            assign right_key   = '0;
            assign right_amt   = '0;
            assign right_name  = '0;
        end else begin : g_inner
            assign right_valid = c_flag[g+1].valid;
            assign right_key   = c_key[g+1];
            assign right_amt   = c_amt[g+1];
            assign right_name  = c_name[g+1];
        end

        srt_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cmd),
            .i_key          (r_key),
            .i_amount       (r_amount),
            .i_name         (r_name),
            .i_left_flag    (left_flag),
            .i_left_key     (left_key),
            .i_left_amount  (left_amt),
            .i_left_name    (left_name),
            .i_right_valid  (right_valid),
            .i_right_key    (right_key),
            .i_right_amount (right_amt),
            .i_right_name   (right_name),
            .i_head_key     (c_key[0]),
            .i_head_amount  (c_amt[0]),
            .i_head_name    (c_name[0]),
            .o_flag         (c_flag[g]),
            .o_key          (c_key[g]),
            .o_amount       (c_amt[g]),
            .o_name         (c_name[g]),
            .o_sel_key      (s_key[g]),
            .o_sel_amount   (s_amt[g]),
            .o_sel_name     (s_name[g])
        );
    end

    // gather the matching record; at most one cell matches
    always_comb begin
        sel_key  = '0;
        sel_amt  = '0;
        sel_name = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_key      = sel_key | s_key[i];
            sel_amt      = sel_amt | s_amt[i];
            sel_name     = sel_name | s_name[i];
            eq_vec[i]    = c_flag[i].eq;
            valid_vec[i] = c_flag[i].valid;
        end
        hit = |eq_vec;
    end

    // list length and emit window
    always_comb begin
        list_n = (int'(r_count) < MAX_OUT) ? int'(r_count) : MAX_OUT;
        emit   = int'(r_idx) < MAX_OUT;
    end

    // sequencer: next state, cell commands and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        cmd      = '0;
        load_out = 1'b0;
        res_st   = ST_OK;
        res_key  = r_key;
        res_amt  = '0;
        res_name = '0;
        res_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                n_idx   = '0;
                if (r_func == F_LIST) begin
                    n_state = (r_count == '0) ? S_IDLE : S_LIST;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                    case (r_func)
                        F_INSERT: begin
                            if (full) begin
                                res_st = ST_FULL;
                            end else if (hit) begin
                                res_st   = ST_EXISTS;
                                res_key  = sel_key;
                                res_amt  = sel_amt;
                                res_name = NAME_PORT_W'(sel_name);
                            end else begin
                                cmd.ins  = 1'b1;
                                n_count  = r_count + 1'b1;
                                res_amt  = r_amount;
                                res_name = NAME_PORT_W'(r_name);
                            end
                        end
                        F_SEARCH, F_UPDATE: begin
                            if (hit) begin
                                cmd.upd  = (r_func == F_UPDATE);
                                res_key  = sel_key;
                                res_amt  = (r_func == F_UPDATE) ? sel_amt + r_amount
                                                                : sel_amt;
                                res_name = NAME_PORT_W'(sel_name);
                            end else begin
                                res_st = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            res_st = ST_OK;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (!emit || out_free) begin
                    cmd.rot  = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    load_out = emit;
                    res_key  = c_key[0];
                    res_amt  = c_amt[0];
                    res_name = NAME_PORT_W'(c_name[0]);
                    res_last = (int'(r_idx) + 1 == list_n);
                    if (int'(r_idx) + 1 == int'(r_count)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func   <= t_func'(i_in.func);
            r_key    <= i_in.part_key;
            r_amount <= i_in.amount;
            r_name   <= in_name_full[NAME_W-1:0];
        end
        if (load_out) begin
            r_ost   <= res_st;
            r_okey  <= res_key;
            r_oamt  <= res_amt;
            r_oname <= res_name;
            r_olast <= res_last;
        end
    end

    // ports
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.status       = r_ost;
    assign o_out.found_key    = r_okey;
    assign o_out.found_amount = r_oamt;
    assign o_out.out_word0    = r_oname[63:0];
    assign o_out.out_word1    = r_oname[127:64];
    assign o_out.out_word2    = r_oname[191:128];
    assign o_out.out_tail     = r_oname[199:192];
    assign o_out.last         = r_olast;

    // checks
    `SRT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `SRT_ASSERT_NOW(a_single_match, r_state == S_APPLY, $onehot0(eq_vec),
        "more than one cell matches the key")
    `SRT_ASSERT_NOW(a_fill_matches, r_state == S_IDLE,
        $countones(valid_vec) == int'(r_count), "filled cells differ from entry count")
    `SRT_ASSERT_NEXT(a_accept_compare, in_acc, r_state == S_CMP,
        "accepted word not followed by compare")

endmodule

### hw/rtl/srt_cell.sv
// one record slot of the sorted chain
module srt_cell import srt_pkg::*; #(
    parameter int NAME_W = NAME_CHARS_DEF * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_cmd          i_cmd,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_amount,
    input  logic [NAME_W-1:0]  i_name,
    input  t_cell_flag         i_left_flag,
    input  logic signed [31:0] i_left_key,
    input  logic signed [31:0] i_left_amount,
    input  logic [NAME_W-1:0]  i_left_name,
    input  logic               i_right_valid,
    input  logic signed [31:0] i_right_key,
    input  logic signed [31:0] i_right_amount,
    input  logic [NAME_W-1:0]  i_right_name,
    input  logic signed [31:0] i_head_key,
    input  logic signed [31:0] i_head_amount,
    input  logic [NAME_W-1:0]  i_head_name,
    output t_cell_flag         o_flag,
    output logic signed [31:0] o_key,
    output logic signed [31:0] o_amount,
    output logic [NAME_W-1:0]  o_name,
    output logic signed [31:0] o_sel_key,
    output logic signed [31:0] o_sel_amount,
    output logic [NAME_W-1:0]  o_sel_name
);

    logic               r_valid;
    logic               r_gt;
    logic               r_eq;
    logic signed [31:0] r_key;
    logic signed [31:0] r_amount;
    logic [NAME_W-1:0]  r_name;

    // a cell not below the new key makes room: takes the new word or the left one
    logic take_new;
    logic take_left;
    logic take_right;
    logic take_head;

    always_comb begin
        take_new   = i_cmd.ins && !r_gt && i_left_flag.gt;
        take_left  = i_cmd.ins && !r_gt && !i_left_flag.gt;
        take_right = i_cmd.rot && r_valid && i_right_valid;
        take_head  = i_cmd.rot && r_valid && !i_right_valid;
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_cmd.cmp) begin
                r_gt <= r_valid && (i_key > r_key);
                r_eq <= r_valid && (i_key == r_key);
            end
            if (take_new) begin
                r_valid <= 1'b1;
            end else if (take_left) begin
                r_valid <= i_left_flag.valid;
            end
        end
    end

    // record payload
    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_key    <= i_key;
            r_amount <= i_amount;
            r_name   <= i_name;
        end else if (take_left) begin
            r_key    <= i_left_key;
            r_amount <= i_left_amount;
            r_name   <= i_left_name;
        end else if (take_right) begin
            r_key    <= i_right_key;
            r_amount <= i_right_amount;
            r_name   <= i_right_name;
        end else if (take_head) begin
            r_key    <= i_head_key;
            r_amount <= i_head_amount;
            r_name   <= i_head_name;
        end else if (i_cmd.upd && r_eq) begin
            r_amount <= r_amount + i_amount;
        end
    end

    // own record and the copy gated by the match flag
    always_comb begin
        o_flag       = '{valid: r_valid, gt: r_gt, eq: r_eq};
        o_key        = r_key;
        o_amount     = r_amount;
        o_name       = r_name;
        o_sel_key    = r_eq ? r_key : '0;
        o_sel_amount = r_eq ? r_amount : '0;
        o_sel_name   = r_eq ? r_name : '0;
    end

endmodule

### test/tb_sorted_record_table_unit.sv
// testbench for the sorted record table: directed and random requests, scoreboard check
module tb_sorted_record_table_unit;
    import srt_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int POOL_SIZE   = 24;

    // one reported record as the block should present it
    typedef struct {
        t_status            status;
        logic signed [31:0] key;
        logic signed [31:0] qty;
        logic [199:0]       name;
        logic               last;
    } t_report;

    // shadow copy of the part table plus the queue of reports still owed
    class part_table_scoreboard;
        logic signed [31:0] keys[$];
        logic signed [31:0] qtys[$];
        logic [199:0]       names[$];
        t_report            owed[$];
        int                 mismatches;

        function int entries();
            return keys.size();
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void owe(t_status st, logic signed [31:0] key, logic signed [31:0] qty,
                          logic [199:0] name, logic last);
            t_report r;
            r.status = st;
            r.key    = key;
            r.qty    = qty;
            r.name   = name;
            r.last   = last;
            owed.push_back(r);
        endfunction

        // characters past the name length are stored as zero
        function logic [199:0] trim_name(logic [199:0] name);
            for (int c = NAME_CHARS_DEF; c < 25; c++) begin
                name[8*c +: 8] = 8'h00;
            end
            return name;
        endfunction

        // work out the reports caused by one accepted request word
        function void note_request(t_func f, logic signed [31:0] key,
                                   logic signed [31:0] amt, logic [199:0] name);
            int pos;
            int n;
            bit hit;
            if (f == F_LIST) begin
                n = (keys.size() < MAX_OUT) ? keys.size() : MAX_OUT;
                for (int i = 0; i < n; i++) begin
                    owe(ST_OK, keys[i], qtys[i], names[i], i == n - 1);
                end
                return;
            end
            pos = 0;
            while (pos < keys.size() && key > keys[pos]) pos++;
            hit = (pos < keys.size()) && (keys[pos] == key);
            case (f)
                F_INSERT: begin
                    if (keys.size() >= TABLE_DEPTH) begin
                        owe(ST_FULL, key, '0, '0, 1'b1);
                    end else if (hit) begin
                        owe(ST_EXISTS, keys[pos], qtys[pos], names[pos], 1'b1);
                    end else begin
                        keys.insert(pos, key);
                        qtys.insert(pos, amt);
                        names.insert(pos, trim_name(name));
                        owe(ST_OK, key, amt, names[pos], 1'b1);
                    end
                end
                default: begin
                    if (!hit) begin
                        owe(ST_NOT_FOUND, key, '0, '0, 1'b1);
                    end else begin
                        // quantity wraps at 32 bits
                        if (f == F_UPDATE) qtys[pos] = qtys[pos] + amt;
                        owe(ST_OK, keys[pos], qtys[pos], names[pos], 1'b1);
                    end
                end
            endcase
        endfunction

        function void match(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $error("%s: expected %h, got %h", field, want, seen);
                mismatches++;
            end
        endfunction

        // compare one accepted result word with the oldest report owed
        function void check_result(t_report got);
            t_report want;
            if (owed.size() == 0) begin
                $error("result word with nothing expected: key %h", got.key);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            match("status", 64'(want.status), 64'(got.status));
            match("found_key", 64'(unsigned'(want.key)), 64'(unsigned'(got.key)));
            match("found_amount", 64'(unsigned'(want.qty)), 64'(unsigned'(got.qty)));
            match("out_word0", want.name[63:0], got.name[63:0]);
            match("out_word1", want.name[127:64], got.name[127:64]);
            match("out_word2", want.name[191:128], got.name[191:128]);
            match("out_tail", 64'(want.name[199:192]), 64'(got.name[199:192]));
            match("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    srt_in_if  req_if();
    srt_out_if rsp_if();

    sorted_record_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    part_table_scoreboard board;
    logic signed [31:0]   key_pool[POOL_SIZE];
    int                   send_calm   = 0;
    int                   recv_calm   = 0;
    int                   stall_left  = 0;
    int unsigned          cycle_count = 0;
    int unsigned          taken_count = 0;
    int unsigned          seen_count  = 0;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // cycles to wait before the next word, with occasional stretches of none
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(5, 30);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [199:0] rand_name();
        return {8'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic signed [31:0] rand_amount();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // mostly keys from a small pool so duplicates and hits are common
    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_func pick_func();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) return F_INSERT;
        if (r < 12) return F_SEARCH;
        if (r < 17) return F_UPDATE;
        return F_LIST;
    endfunction

    // send one request word; starts and ends at a falling edge
    task automatic send_request(t_func f, logic signed [31:0] key,
                                logic signed [31:0] amt, logic [199:0] name);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= f;
        req_if.part_key   <= key;
        req_if.amount     <= amt;
        req_if.name_word0 <= name[63:0];
        req_if.name_word1 <= name[127:64];
        req_if.name_word2 <= name[191:128];
        req_if.name_tail  <= name[199:192];
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(f, key, amt, name);
        @(negedge i_clk);
    endtask

    task automatic idle_sender();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // hold off until every owed report has arrived
    task automatic wait_drained();
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    // result side: ready drops for a random stall after each accepted word
    always @(negedge i_clk) begin
        if (taken_count != seen_count) begin
            seen_count = taken_count;
            stall_left = draw_wait(recv_calm);
        end
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_report got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status = t_status'(rsp_if.status);
            got.key    = rsp_if.found_key;
            got.qty    = rsp_if.found_amount;
            got.name   = {rsp_if.out_tail, rsp_if.out_word2, rsp_if.out_word1,
                          rsp_if.out_word0};
            got.last   = rsp_if.last;
            board.check_result(got);
            taken_count++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sorted_record_table_unit: FAIL");
            $finish;
        end
    end

    initial begin
        board             = new();
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.func       = F_INSERT;
        req_if.part_key   = '0;
        req_if.amount     = '0;
        req_if.name_word0 = '0;
        req_if.name_word1 = '0;
        req_if.name_word2 = '0;
        req_if.name_tail  = '0;

        // key pool: extremes, neighbors and random values
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sh8000_0001;
        key_pool[5] = 32'sh7FFF_FFFE;
        for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, duplicate, wraparound, not found
        send_request(F_LIST, 32'sd0, 32'sd0, '0);
        send_request(F_SEARCH, 32'sd0, 32'sd0, '0);
        send_request(F_UPDATE, 32'sd5, 32'sd7, '0);
        send_request(F_INSERT, 32'sd0, 32'sd0, '0);
        send_request(F_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, '1);
        send_request(F_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     200'h41_4D4D_3034_0000_4C41_4553_2D47_4E49_5241_4542_0000_0000);
        send_request(F_INSERT, -32'sd1, -32'sd1, rand_name());
        send_request(F_INSERT, 32'sd1, 32'sd1, rand_name());
        send_request(F_INSERT, 32'sd0, 32'sd99, rand_name());
        send_request(F_SEARCH, 32'sh8000_0000, 32'sd0, rand_name());
        send_request(F_SEARCH, 32'sh7FFF_FFFF, 32'sd0, '0);
        send_request(F_SEARCH, 32'sd2, 32'sd0, '0);
        send_request(F_UPDATE, 32'sh8000_0000, 32'sd1, '0);
        send_request(F_UPDATE, 32'sh7FFF_FFFF, -32'sd1, '0);
        send_request(F_UPDATE, -32'sd1, 32'sh8000_0000, '0);
        send_request(F_UPDATE, 32'sd3, 32'sd1, '0);
        send_request(F_LIST, 32'sd0, 32'sd0, '0);
        send_request(F_INSERT, 32'sh7FFF_FFFE, 32'sd12, rand_name());
        send_request(F_LIST, $urandom, $urandom, rand_name());

        // sender holds off until the table has answered everything
        idle_sender();
        wait_drained();

        // random mix over a small key pool
        for (int i = 0; i < 130; i++) begin
            send_request(pick_func(), pick_key(), rand_amount(), rand_name());
        end

        idle_sender();
        wait_drained();

        // fill the table to capacity, then probe the full table
        while (board.entries() < TABLE_DEPTH) begin
            send_request(F_INSERT, $urandom, rand_amount(), rand_name());
        end
        send_request(F_INSERT, board.keys[TABLE_DEPTH / 2], rand_amount(), rand_name());
        send_request(F_INSERT, $urandom, rand_amount(), rand_name());
        send_request(F_LIST, 32'sd0, 32'sd0, '0);
        send_request(F_SEARCH, board.keys[0], 32'sd0, '0);
        send_request(F_UPDATE, board.keys[TABLE_DEPTH - 1], rand_amount(), '0);
        send_request(F_SEARCH, $urandom, 32'sd0, '0);
        send_request(F_LIST, 32'sd0, 32'sd0, '0);

        idle_sender();
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb_sorted_record_table_unit: PASS");
        end else begin
            $display("tb_sorted_record_table_unit: FAIL");
        end
        $finish;
    end

endmodule
